// ===== src/hbc_pkg.sv =====
// ============================================================================
// hbc_pkg
// Shared sizes, codes and types for the histogram bar chart renderer.
// ============================================================================
package hbc_pkg;

    localparam int NUM_BINS   = 256;
    localparam int MAX_DIM    = 4096;
    localparam int COUNT_BITS = 32;

    localparam int BIN_BITS   = $clog2(NUM_BINS);
    localparam int COORD_BITS = $clog2(MAX_DIM);
    localparam int DIM_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS  = DIM_BITS + COUNT_BITS;

    // Bar height is 0.95 of the canvas, kept exact as a fraction
    localparam int BAR_NUM = 19;
    localparam int BAR_DEN = 20;

    localparam logic [7:0] PIX_ON  = 8'd255;
    localparam logic [7:0] PIX_OFF = 8'd0;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic REG_HEIGHT = 1'b0;
    localparam logic REG_WIDTH  = 1'b1;

    localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(256);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_CMP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                  en;
        logic [BIN_BITS-1:0]   addr;
        logic [COUNT_BITS-1:0] data;
    } t_store_wr;

    typedef struct packed {
        logic                done;
        logic [BIN_BITS-1:0] bin;
    } t_div_status;

endpackage

// ===== src/histogram_bar_chart_render.sv =====
// ============================================================================
// histogram_bar_chart_render
// Bar chart pixel source over a stored histogram with a running peak.
// ============================================================================
// Sequence: a load, a clear, an unused op or a query that falls off the
// chart (or meets a zero peak or dimension) goes straight to the output
// stage; a real query first passes the one-bit-a-cycle column divider, then
// the RAM read, the multiply and the compare.
// Flow: one item at a time; the next transfer is taken the cycle after the
// result enters the output register, which waits while the receiver holds
// off. Synchronous active-low reset clears the peak, the bin valid bits and
// the control; height and width go to 256.
// ============================================================================
module histogram_bar_chart_render
    import hbc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_op,
    input  logic [7:0]            i_bin_index,
    input  logic [31:0]           i_bin_count,
    input  logic [11:0]           i_row,
    input  logic [11:0]           i_column,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_pixel,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [DIM_BITS-1:0]   i_cfg_data
);

    t_state                r_state;
    t_state                n_state;

    logic [DIM_BITS-1:0]   r_height;
    logic [DIM_BITS-1:0]   r_width;
    logic [COUNT_BITS-1:0] r_peak;
    logic [DIM_BITS-1:0]   r_rows_below;
    logic [7:0]            r_px;
    logic [7:0]            r_pixel;
    logic                  r_out_valid;

    logic                  in_xfer;
    logic                  cfg_xfer;
    logic                  out_xfer;
    logic                  slot_free;
    logic                  off_chart;
    logic                  load_ok;
    logic [COUNT_BITS-1:0] load_count;

    // sequencer outputs
    logic                  div_start;
    logic                  rd_en;
    logic                  cmp_en;
    logic                  px_load;
    logic                  out_load;

    t_store_wr             store_wr;
    t_div_status           div_status;
    logic [COUNT_BITS-1:0] rd_data;
    logic                  white;

    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid & o_cfg_ready;
    assign in_xfer     = i_in_valid & o_in_ready;
    assign out_xfer    = r_out_valid & i_out_ready;
    assign slot_free   = !r_out_valid || i_out_ready;

    // a query outside the canvas, or with nothing to scale against, is dark
    assign off_chart = (r_height == '0) || (r_width == '0) || (r_peak == '0)
                     || (DIM_BITS'(i_row) >= r_height)
                     || (DIM_BITS'(i_column) >= r_width);

    assign load_count = COUNT_BITS'(i_bin_count);
    assign load_ok    = (32'(i_bin_index) < NUM_BINS);

    assign store_wr.en   = in_xfer && (i_op == OP_LOAD) && load_ok;
    assign store_wr.addr = BIN_BITS'(i_bin_index);
    assign store_wr.data = load_count;

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if ((i_op == OP_QUERY) && !off_chart) begin
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- outputs
    always_comb begin
        o_in_ready = 1'b0;
        div_start  = 1'b0;
        rd_en      = 1'b0;
        cmp_en     = 1'b0;
        px_load    = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                div_start  = i_in_valid && (i_op == OP_QUERY) && !off_chart;
            end
            ST_DIV: begin
                rd_en = div_status.done;
            end
            ST_MUL: begin
                cmp_en = 1'b1;
            end
            ST_CMP: begin
                px_load = 1'b1;
            end
            ST_OUT: begin
                out_load = slot_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_height    <= DIM_RESET;
            r_width     <= DIM_RESET;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (cfg_xfer) begin
                case (i_cfg_index)
                    REG_HEIGHT: r_height <= i_cfg_data;
                    REG_WIDTH:  r_width  <= i_cfg_data;
                    default:    r_height <= r_height;
                endcase
            end

            // the peak tracks the largest load since the last clear
            if (in_xfer && (i_op == OP_CLEAR)) begin
                r_peak <= '0;
            end else if (store_wr.en && (load_count > r_peak)) begin
                r_peak <= load_count;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_px         <= PIX_OFF;
            r_rows_below <= r_height - DIM_BITS'(i_row) - 1'b1;
        end else if (px_load) begin
            r_px <= white ? PIX_ON : PIX_OFF;
        end
        if (out_load) begin
            r_pixel <= r_px;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel     = r_pixel;

    // ---------------------------------------------------------------- units
    hbc_bin_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (in_xfer && (i_op == OP_CLEAR)),
        .i_wr      (store_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (div_status.bin),
        .o_rd_data (rd_data)
    );

    hbc_col_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_col    (COORD_BITS'(i_column)),
        .i_width  (r_width),
        .o_status (div_status)
    );

    hbc_bar_cmp u_cmp (
        .i_clk        (i_clk),
        .i_en         (cmp_en),
        .i_height     (r_height),
        .i_rows_below (r_rows_below),
        .i_count      (rd_data),
        .i_peak       (r_peak),
        .o_white      (white)
    );

endmodule

// ===== src/hbc_bin_store.sv =====
// ============================================================================
// hbc_bin_store
// Bin count memory with a registered read and per-entry valid bits.
// ============================================================================
module hbc_bin_store
    import hbc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clr,
    input  t_store_wr             i_wr,
    input  logic                  i_rd_en,
    input  logic [BIN_BITS-1:0]   i_rd_addr,
    output logic [COUNT_BITS-1:0] o_rd_data
);

    logic [COUNT_BITS-1:0] r_mem [NUM_BINS];
    logic [NUM_BINS-1:0]   r_valid;
    logic [COUNT_BITS-1:0] r_rd_data;
    logic                  r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    // a bin never loaded since the last clear reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// ===== src/hbc_col_div.sv =====
// ============================================================================
// hbc_col_div
// Column to bin mapping: floor(((col+1)*NUM_BINS-1)/width), one bit a cycle.
// ============================================================================
module hbc_col_div
    import hbc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COORD_BITS-1:0] i_col,
    input  logic [DIM_BITS-1:0]   i_width,
    output t_div_status           o_status
);

    localparam int DVD_BITS = COORD_BITS + 1 + BIN_BITS;
    localparam int CNT_BITS = $clog2(BIN_BITS + 1);

    logic [DIM_BITS-1:0]   r_rem;
    logic [BIN_BITS-1:0]   r_sh;
    logic [CNT_BITS-1:0]   r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DVD_BITS-1:0]   dvd;
    logic [COORD_BITS:0]   col_p1;
    logic [DIM_BITS:0]     trial;
    logic [DIM_BITS:0]     diff;
    logic                  ge;

    // the column lies inside the canvas, so the upper dividend bits stay below width
    assign col_p1 = {1'b0, i_col} + 1'b1;
    assign dvd    = DVD_BITS'(col_p1) * DVD_BITS'(NUM_BINS) - DVD_BITS'(1);
    assign trial  = {r_rem, r_sh[BIN_BITS-1]};
    assign diff   = trial - {1'b0, i_width};
    assign ge     = (trial >= {1'b0, i_width});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DIM_BITS'(dvd >> BIN_BITS);
            r_sh  <= dvd[BIN_BITS-1:0];
        end else if (r_busy) begin
            r_rem <= ge ? DIM_BITS'(diff) : DIM_BITS'(trial);
            r_sh  <= BIN_BITS'({r_sh, ge});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(BIN_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_status.done = r_done;
    assign o_status.bin  = r_sh;

endmodule

// ===== src/hbc_bar_cmp.sv =====
// ============================================================================
// hbc_bar_cmp
// Bar test: BAR_NUM*H*count > BAR_DEN*peak*(H-row-1), products registered.
// ============================================================================
module hbc_bar_cmp
    import hbc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [DIM_BITS-1:0]   i_height,
    input  logic [DIM_BITS-1:0]   i_rows_below,
    input  logic [COUNT_BITS-1:0] i_count,
    input  logic [COUNT_BITS-1:0] i_peak,
    output logic                  o_white
);

    localparam int CMP_BITS = PROD_BITS + 5;

    logic [PROD_BITS-1:0] r_lhs;
    logic [PROD_BITS-1:0] r_rhs;
    logic [CMP_BITS-1:0]  lhs_scaled;
    logic [CMP_BITS-1:0]  rhs_scaled;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lhs <= PROD_BITS'(i_height) * PROD_BITS'(i_count);
            r_rhs <= PROD_BITS'(i_rows_below) * PROD_BITS'(i_peak);
        end
    end

    assign lhs_scaled = CMP_BITS'(r_lhs) * CMP_BITS'(BAR_NUM);
    assign rhs_scaled = CMP_BITS'(r_rhs) * CMP_BITS'(BAR_DEN);
    assign o_white    = (lhs_scaled > rhs_scaled);

endmodule

// ===== verif/tb_top.sv =====
// ============================================================================
// tb_top
// Self-checking bench for histogram_bar_chart_render: a directed table of
// loads, queries, clears and corner pixels, then constrained-by-hand random
// traffic over a sweep of canvas sizes (zero, one, widest, odd shapes).
// Every pixel that comes out is checked against a typed-in value or an
// in-bench bar chart model that keeps its own bins, peak and canvas size.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hbc_pkg::*;

    localparam int IDLE_PCT         = 14;   // chance of an idle cycle per side
    localparam int HOLD_CYCLES      = 300;  // long receiver hold-off
    localparam int CFG_SETTLE       = 16;   // quiet cycles before a register write
    localparam int TAIL_CYCLES      = 30;   // watch for stray pixels after the last
    localparam int WATCHDOG_LIMIT   = 2000; // cycles with no transfer on any channel
    localparam int RANDOM_PER_PHASE = 90;
    localparam int NUM_PHASES       = 12;
    localparam int QUIET_PHASE      = 4;    // no idling on either side
    localparam int HOLD_PHASE       = 7;    // receiver stalls, sender keeps offering
    localparam int PAUSE_PHASE      = 10;   // sender waits for a full drain
    localparam int MAX_REPORTS      = 10;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  bin;
        logic [31:0] count;
        logic [11:0] row;
        logic [11:0] column;
    } t_render_item;

    typedef struct packed {
        t_render_item item;
        logic         fixed;    // pixel below is typed in, not predicted
        logic [7:0]   pixel;
    } t_directed_row;

    // ------------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------------
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    logic [1:0]          i_op        = OP_LOAD;
    logic [7:0]          i_bin_index = '0;
    logic [31:0]         i_bin_count = '0;
    logic [11:0]         i_row       = '0;
    logic [11:0]         i_column    = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [7:0]          o_pixel;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_index = REG_HEIGHT;
    logic [DIM_BITS-1:0] i_cfg_data  = '0;

    // ------------------------------------------------------------------------
    // Chart model state and scoreboard
    // ------------------------------------------------------------------------
    logic [COUNT_BITS-1:0] hist_bins [NUM_BINS];
    logic [COUNT_BITS-1:0] hist_peak;
    logic [DIM_BITS-1:0]   canvas_h;
    logic [DIM_BITS-1:0]   canvas_w;

    logic [7:0]    expected_pixels [$];
    t_directed_row dir_rows [$];
    logic [7:0]    wanted_pixel;

    bit idle_on       = 1'b1;
    bit hold_request  = 1'b0;
    int fail_count    = 0;
    int mismatches    = 0;
    int pixels_seen   = 0;
    int lit_pixels    = 0;
    int items_sent    = 0;
    int queries_sent  = 0;
    int canvas_writes = 0;
    int holds_done    = 0;
    int stall_cycles  = 0;

    histogram_bar_chart_render dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_bin_index (i_bin_index),
        .i_bin_count (i_bin_count),
        .i_row       (i_row),
        .i_column    (i_column),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pixel     (o_pixel),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------------
    // Bar chart predictor: apply one accepted item to the model state and
    // return the pixel it must produce. Bar test is 19*H*count > 20*peak*(H-r-1),
    // done on 64 bits so it stays exact for any 13-bit canvas size.
    // ------------------------------------------------------------------------
    function automatic logic [7:0] predict_pixel(input t_render_item it);
        logic [63:0] h, w, r, c, bin, lhs, rhs;
        h = 64'(canvas_h);
        w = 64'(canvas_w);
        r = 64'(it.row);
        c = 64'(it.column);
        case (it.op)
            OP_LOAD: begin
                hist_bins[it.bin] = it.count;
                if (it.count > hist_peak)
                    hist_peak = it.count;
                return PIX_OFF;
            end
            OP_QUERY: begin
                // zero peak, empty canvas or off-canvas pixel stays dark
                if (hist_peak == '0 || h == 0 || w == 0 || r >= h || c >= w)
                    return PIX_OFF;
                bin = ((c + 1) * 64'(NUM_BINS) + w - 1) / w - 1;
                lhs = 64'(BAR_NUM) * h * 64'(hist_bins[bin[BIN_BITS-1:0]]);
                rhs = 64'(BAR_DEN) * 64'(hist_peak) * (h - r - 1);
                return (lhs > rhs) ? PIX_ON : PIX_OFF;
            end
            OP_CLEAR: begin
                foreach (hist_bins[i])
                    hist_bins[i] = '0;
                hist_peak = '0;
                return PIX_OFF;
            end
            default: return PIX_OFF;
        endcase
    endfunction

    // Offer one item, hold it until the transfer, then record its pixel.
    // Returns on the transfer edge with valid still high so back-to-back
    // items need no second assignment in the same step.
    task automatic send_item(input t_render_item it, input logic fixed,
                             input logic [7:0] fixed_px);
        int         gap;
        logic [7:0] px;
        gap = 0;
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_op        <= it.op;
        i_bin_index <= it.bin;
        i_bin_count <= it.count;
        i_row       <= it.row;
        i_column    <= it.column;
        do @(posedge i_clk); while (!o_in_ready);
        px = predict_pixel(it);
        expected_pixels.push_back(fixed ? fixed_px : px);
        items_sent++;
        if (it.op == OP_QUERY)
            queries_sent++;
    endtask

    task automatic write_register(input logic idx, input logic [DIM_BITS-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_HEIGHT)
            canvas_h = val;
        else
            canvas_w = val;
        canvas_writes++;
    endtask

    task automatic add_row(input logic [1:0] op, input logic [7:0] bin,
                           input logic [31:0] count, input logic [11:0] row,
                           input logic [11:0] column, input logic fixed,
                           input logic [7:0] pixel);
        t_directed_row d;
        d.item  = '{op: op, bin: bin, count: count, row: row, column: column};
        d.fixed = fixed;
        d.pixel = pixel;
        dir_rows.push_back(d);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random ready, or a long hold-off when asked for one
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                // hold off while the sender keeps offering, so the input stalls
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_done++;
            end else begin
                i_out_ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Pixel checker: compare every transfer with the oldest expected pixel
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            pixels_seen++;
            if (expected_pixels.size() == 0) begin
                fail_count++;
                if (mismatches < MAX_REPORTS)
                    $display("pixel %0d: got %0d with nothing outstanding",
                             pixels_seen, o_pixel);
                mismatches++;
            end else begin
                wanted_pixel = expected_pixels.pop_front();
                if (o_pixel !== wanted_pixel) begin
                    fail_count++;
                    if (mismatches < MAX_REPORTS)
                        $display("pixel %0d: expected %0d, got %0d",
                                 pixels_seen, wanted_pixel, o_pixel);
                    mismatches++;
                end else if (wanted_pixel == PIX_ON) begin
                    lit_pixels++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: the slowest legal gap is the receiver hold-off plus a real
    // query and the settle before a register write, well under the limit.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d pixels outstanding",
                     stall_cycles, expected_pixels.size());
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_render_item it;
        int unsigned  h, w, lim, roll, last_bin;

        foreach (hist_bins[i])
            hist_bins[i] = '0;
        hist_peak = '0;
        canvas_h  = DIM_RESET;
        canvas_w  = DIM_RESET;
        last_bin  = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on the 256 x 256 canvas left by reset.
        // Zero peak after reset: dark even at the bottom row.
        add_row(OP_QUERY, 8'd0,   32'd0,          12'd255,  12'd0,    1'b1, PIX_OFF);
        add_row(OP_LOAD,  8'd0,   32'hFFFF_FFFF,  12'd0,    12'd0,    1'b1, PIX_OFF);
        add_row(OP_LOAD,  8'd255, 32'd1,          12'd0,    12'd0,    1'b1, PIX_OFF);
        // Bin at the peak lights the bottom row
        add_row(OP_QUERY, 8'd0,   32'd0,          12'd255,  12'd0,    1'b1, PIX_ON);
        // Bar top sits at 0.95 of the canvas: rows 0, 12 and 13
        add_row(OP_QUERY, 8'd0,   32'd0,          12'd0,    12'd0,    1'b0, PIX_OFF);
        add_row(OP_QUERY, 8'd0,   32'd0,          12'd12,   12'd0,    1'b0, PIX_OFF);
        add_row(OP_QUERY, 8'd0,   32'd0,          12'd13,   12'd0,    1'b0, PIX_OFF);
        // Row or column off the canvas
        add_row(OP_QUERY, 8'hFF,  32'hFFFF_FFFF,  12'hFFF,  12'd0,    1'b1, PIX_OFF);
        add_row(OP_QUERY, 8'hFF,  32'hFFFF_FFFF,  12'd255,  12'hFFF,  1'b1, PIX_OFF);
        // Tiny count against a huge peak, last bin
        add_row(OP_QUERY, 8'd0,   32'd0,          12'd255,  12'd255,  1'b0, PIX_OFF);
        add_row(OP_QUERY, 8'd0,   32'd0,          12'd254,  12'd255,  1'b0, PIX_OFF);
        add_row(OP_LOAD,  8'd128, 32'h8000_0000,  12'd0,    12'd0,    1'b1, PIX_OFF);
        // Rewrite without a clear: bin shrinks, peak stays
        add_row(OP_LOAD,  8'd0,   32'd7,          12'd0,    12'd0,    1'b1, PIX_OFF);
        add_row(OP_QUERY, 8'd0,   32'd0,          12'd255,  12'd0,    1'b0, PIX_OFF);
        add_row(OP_QUERY, 8'd0,   32'd0,          12'd255,  12'd128,  1'b0, PIX_OFF);
        // Unused op: dark, no state change
        add_row(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF,  12'hFFF,  12'hFFF,  1'b1, PIX_OFF);
        add_row(OP_QUERY, 8'd0,   32'd0,          12'd200,  12'd128,  1'b0, PIX_OFF);
        add_row(OP_CLEAR, 8'd0,   32'd0,          12'd0,    12'd0,    1'b1, PIX_OFF);
        add_row(OP_QUERY, 8'd0,   32'd0,          12'd255,  12'd128,  1'b1, PIX_OFF);
        // Zero count keeps the peak at zero, so still dark
        add_row(OP_LOAD,  8'd17,  32'd0,          12'd0,    12'd0,    1'b1, PIX_OFF);
        add_row(OP_QUERY, 8'd0,   32'd0,          12'd255,  12'd17,   1'b1, PIX_OFF);
        add_row(OP_LOAD,  8'd200, 32'h0000_0ABC,  12'd0,    12'd0,    1'b1, PIX_OFF);
        add_row(OP_QUERY, 8'd0,   32'd0,          12'd255,  12'd200,  1'b0, PIX_OFF);
        add_row(OP_QUERY, 8'd0,   32'd0,          12'd255,  12'd17,   1'b0, PIX_OFF);
        add_row(OP_QUERY, 8'd0,   32'd0,          12'd0,    12'd200,  1'b0, PIX_OFF);

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].pixel);
        i_in_valid <= 1'b0;

        // Random part: one canvas setting per phase, extremes first
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       begin h = 1;    w = 1;    end
                1:       begin h = 8191; w = 8191; end
                2:       begin h = 0;    w = 256;  end
                3:       begin h = 256;  w = 0;    end
                4:       begin h = 4096; w = 4096; end
                5:       begin h = 4095; w = 3;    end
                6:       begin h = 3;    w = 4095; end
                7:       begin h = 1000; w = 640;  end
                11:      begin h = 256;  w = 256;  end
                default: begin
                    h = $urandom_range(1, 4200);
                    w = $urandom_range(1, 4200);
                end
            endcase

            // Drain, let the block settle, then reprogram the canvas
            while (expected_pixels.size() != 0)
                @(posedge i_clk);
            repeat (CFG_SETTLE) @(posedge i_clk);
            idle_on = (p != QUIET_PHASE);
            write_register(REG_HEIGHT, h[DIM_BITS-1:0]);
            write_register(REG_WIDTH,  w[DIM_BITS-1:0]);

            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (p == HOLD_PHASE && n == 30)
                    hold_request = 1'b1;
                if (p == PAUSE_PHASE && n == 45) begin
                    // pause the sender until every pixel has come back
                    i_in_valid <= 1'b0;
                    do @(posedge i_clk); while (expected_pixels.size() != 0);
                end

                // unused fields still toggle every bit
                it.bin    = 8'($urandom);
                it.count  = $urandom;
                it.row    = 12'($urandom);
                it.column = 12'($urandom);
                roll = $urandom_range(0, 99);
                if (roll < 32) begin
                    it.op = OP_LOAD;
                    last_bin = 32'(it.bin);
                    case ($urandom_range(0, 9))
                        4, 5, 6: it.count = $urandom_range(0, 1000);
                        7, 8:    it.count = hist_peak + 32'($urandom_range(0, 2)) - 32'd1;
                        9:       it.count = $urandom_range(0, 1) ? '1 : '0;
                        default: ;
                    endcase
                end else if (roll < 97) begin
                    it.op = OP_QUERY;
                    if (canvas_h != 0 && $urandom_range(0, 99) < 85) begin
                        lim = (32'(canvas_h) > MAX_DIM) ? MAX_DIM : 32'(canvas_h);
                        it.row = 12'($urandom_range(0, lim - 1));
                    end
                    if (canvas_w != 0) begin
                        lim  = (32'(canvas_w) > MAX_DIM) ? MAX_DIM : 32'(canvas_w);
                        roll = $urandom_range(0, 99);
                        // aim at the last loaded bin, else anywhere on the canvas or off it
                        if (roll < 40)
                            it.column = 12'((last_bin * lim) / NUM_BINS);
                        else if (roll < 85)
                            it.column = 12'($urandom_range(0, lim - 1));
                    end
                end else if (roll < 98) begin
                    it.op = OP_CLEAR;
                end else begin
                    it.op = OP_UNUSED;
                end
                send_item(it, 1'b0, PIX_OFF);
            end
            i_in_valid <= 1'b0;
        end

        // Wait out the last pixels, then watch for strays
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        fail_count += expected_pixels.size();
        if (mismatches > MAX_REPORTS)
            $display("%0d further pixel errors not listed", mismatches - MAX_REPORTS);

        $display("run: %0d items (%0d directed), %0d queries, %0d of %0d pixels lit",
                 items_sent, dir_rows.size(), queries_sent, lit_pixels, pixels_seen);
        $display("run: %0d canvas register writes over %0d settings, %0d long output stalls",
                 canvas_writes, NUM_PHASES + 1, holds_done);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
